// ===== rtl/tick_driven_uart_8n1_with_fifos_top_assert.svh =====
// ----------------------------------------------------------------------------
// UART assertion macros
// Shorthand for the concurrent checks at the end of the UART top level.
// ----------------------------------------------------------------------------
`ifndef TICK_DRIVEN_UART_8N1_WITH_FIFOS_TOP_ASSERT_SVH
`define TICK_DRIVEN_UART_8N1_WITH_FIFOS_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tdu_pkg.sv =====
// ----------------------------------------------------------------------------
// UART package
// Types, codes and default constants of the tick driven 8N1 UART.
// ----------------------------------------------------------------------------
`default_nettype none

package tdu_pkg;

  localparam int TX_DEPTH_DEFAULT = 16;
  localparam int RX_DEPTH_DEFAULT = 16;

  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int FILL_W  = 5;
  localparam int PHASE_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [BYTE_W-1:0] SAMPLE_THRESHOLD_RESET = 8'd120;

  localparam logic [1:0] FIRST_DELAY_SHORT = 2'd2;
  localparam logic [1:0] FIRST_DELAY_LONG  = 2'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_EDGE = 2'd1,
    CMD_PUT  = 2'd2,
    CMD_GET  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_THRESHOLD = 1'b0,
    REG_RX_ENABLE        = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_START = 3'b010,
    MODE_DATA  = 3'b100
  } mode_t;

endpackage

`default_nettype wire

// ===== rtl/tick_driven_uart_8n1_with_fifos_top.sv =====
// ----------------------------------------------------------------------------
// Tick driven 8N1 UART with FIFOs
// Channel     | Handshake           | Payload
// input       | in_valid / in_stall | cmd, rx_level, timer_phase, data_in
// result      | out_valid/out_stall | tx_level, data_out, accepted, rx_fill,
//             |                     | tx_fill, overflow
// config      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One request is taken every cycle while in_stall is low; its result passes
// from the input register into the result register, which drives out_valid.
// Each FIFO is a memory with one write port and one registered read port.
// Reset clears all control state; the FIFO memories are not cleared.
// A stalled result holds the result register and, behind it, the input one.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tick_driven_uart_8n1_with_fifos_top_assert.svh"

module tick_driven_uart_8n1_with_fifos_top #(
  parameter int TX_DEPTH = tdu_pkg::TX_DEPTH_DEFAULT,
  parameter int RX_DEPTH = tdu_pkg::RX_DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [tdu_pkg::CMD_W-1:0]       cmd,
  input  wire logic                            rx_level,
  input  wire logic [tdu_pkg::PHASE_W-1:0]     timer_phase,
  input  wire logic [tdu_pkg::BYTE_W-1:0]      data_in,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 tx_level,
  output logic [tdu_pkg::BYTE_W-1:0]           data_out,
  output logic                                 accepted,
  output logic [tdu_pkg::FILL_W-1:0]           rx_fill,
  output logic [tdu_pkg::FILL_W-1:0]           tx_fill,
  output logic                                 overflow,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tdu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tdu_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tdu_pkg::*;

  localparam int TxPtrW = $clog2(TX_DEPTH);
  localparam int RxPtrW = $clog2(RX_DEPTH);
  localparam int TxCntW = $clog2(TX_DEPTH + 1);
  localparam int RxCntW = $clog2(RX_DEPTH + 1);

  logic [BYTE_W-1:0]  sample_threshold;
  logic               rx_enable;

  logic               in_full;
  cmd_t               cmd_r;
  logic               rx_level_r;
  logic [PHASE_W-1:0] timer_phase_r;
  logic [BYTE_W-1:0]  data_in_r;
  logic               advance;

  logic [BYTE_W-1:0]  tx_mem [TX_DEPTH];
  logic [BYTE_W-1:0]  rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0]  tx_rd;
  logic [BYTE_W-1:0]  rx_rd;
  logic               tx_we;
  logic               rx_we;

  logic [TxPtrW-1:0]  tx_head, tx_head_next, tx_tail, tx_tail_next;
  logic [TxCntW-1:0]  tx_count, tx_count_next;
  logic [RxPtrW-1:0]  rx_head, rx_head_next, rx_tail, rx_tail_next;
  logic [RxCntW-1:0]  rx_count, rx_count_next;

  mode_t              tx_mode, tx_mode_next;
  logic [3:0]         tx_bit_index, tx_bit_index_next;
  logic               tx_half, tx_half_next;
  logic               line_out, line_out_next;

  mode_t              rx_mode, rx_mode_next;
  logic [BYTE_W-1:0]  rx_shift, rx_shift_next;
  logic [3:0]         rx_bit_index, rx_bit_index_next;
  logic               rx_half, rx_half_next;
  logic [1:0]         rx_delay, rx_delay_next;
  logic               overflow_flag, overflow_flag_next;

  logic [BYTE_W-1:0]  dout_next;
  logic               acc_next;

  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && out_valid && out_stall;
  assign cfg_ready = !in_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_threshold <= SAMPLE_THRESHOLD_RESET;
      rx_enable        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SAMPLE_THRESHOLD: sample_threshold <= cfg_data;
        REG_RX_ENABLE:        rx_enable        <= cfg_data[0];
        default:              rx_enable        <= rx_enable;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r         <= cmd_t'(cmd);
      rx_level_r    <= rx_level;
      timer_phase_r <= timer_phase;
      data_in_r     <= data_in;
    end
  end

  always_comb begin
    tx_head_next       = tx_head;
    tx_tail_next       = tx_tail;
    tx_count_next      = tx_count;
    rx_head_next       = rx_head;
    rx_tail_next       = rx_tail;
    rx_count_next      = rx_count;
    tx_mode_next       = tx_mode;
    tx_bit_index_next  = tx_bit_index;
    tx_half_next       = tx_half;
    line_out_next      = line_out;
    rx_mode_next       = rx_mode;
    rx_shift_next      = rx_shift;
    rx_bit_index_next  = rx_bit_index;
    rx_half_next       = rx_half;
    rx_delay_next      = rx_delay;
    overflow_flag_next = overflow_flag;
    tx_we              = 1'b0;
    rx_we              = 1'b0;
    dout_next          = '0;
    acc_next           = 1'b0;
    if (advance) begin
      unique case (cmd_r)
        CMD_TICK: begin
          unique case (rx_mode)
            MODE_START: begin
              if (rx_delay == 2'd0) begin
                if (rx_level_r && !rx_bit_index[3]) begin
                  rx_shift_next[rx_bit_index[2:0]] = 1'b1;
                end
                rx_bit_index_next = 4'(rx_bit_index + 4'd1);
                rx_half_next      = 1'b0;
                rx_mode_next      = MODE_DATA;
              end else begin
                rx_delay_next = 2'(rx_delay - 2'd1);
              end
            end
            MODE_DATA: begin
              if (rx_half) begin
                rx_half_next = 1'b0;
                if (rx_bit_index[3]) begin
                  if (rx_level_r) begin
                    if (rx_count < RxCntW'(RX_DEPTH)) begin
                      rx_we         = 1'b1;
                      rx_count_next = RxCntW'(rx_count + 1'b1);
                      rx_tail_next  = (rx_tail == RxPtrW'(RX_DEPTH - 1)) ? '0 :
                                      RxPtrW'(rx_tail + 1'b1);
                    end else begin
                      overflow_flag_next = 1'b1;
                    end
                  end
                  rx_bit_index_next = '0;
                  rx_shift_next     = '0;
                  rx_mode_next      = MODE_IDLE;
                end else begin
                  if (rx_level_r) begin
                    rx_shift_next[rx_bit_index[2:0]] = 1'b1;
                  end
                  rx_bit_index_next = 4'(rx_bit_index + 4'd1);
                end
              end else begin
                rx_half_next = 1'b1;
              end
            end
            default: rx_half_next = 1'b1;
          endcase

          if (!tx_half) begin
            tx_half_next = 1'b1;
          end else begin
            tx_half_next = 1'b0;
            if (tx_mode == MODE_START || (tx_mode == MODE_DATA && !tx_bit_index[3])) begin
              line_out_next     = tx_rd[tx_bit_index[2:0]];
              tx_bit_index_next = 4'(tx_bit_index + 4'd1);
              tx_mode_next      = MODE_DATA;
            end else if (tx_mode == MODE_DATA) begin
              line_out_next = 1'b1;
              if (tx_count != '0) begin
                tx_head_next  = (tx_head == TxPtrW'(TX_DEPTH - 1)) ? '0 :
                                TxPtrW'(tx_head + 1'b1);
                tx_count_next = TxCntW'(tx_count - 1'b1);
              end
              tx_mode_next = MODE_IDLE;
            end else if (tx_count != '0) begin
              line_out_next     = 1'b0;
              tx_bit_index_next = '0;
              tx_mode_next      = MODE_START;
            end
          end
        end
        CMD_EDGE: begin
          if (rx_enable && rx_mode == MODE_IDLE && !rx_level_r) begin
            rx_delay_next = (timer_phase_r < sample_threshold) ? FIRST_DELAY_SHORT :
                            FIRST_DELAY_LONG;
            rx_mode_next  = MODE_START;
          end
        end
        CMD_PUT: begin
          if (tx_count < TxCntW'(TX_DEPTH)) begin
            tx_we         = 1'b1;
            tx_count_next = TxCntW'(tx_count + 1'b1);
            tx_tail_next  = (tx_tail == TxPtrW'(TX_DEPTH - 1)) ? '0 :
                            TxPtrW'(tx_tail + 1'b1);
            acc_next      = 1'b1;
          end
        end
        CMD_GET: begin
          if (rx_count != '0) begin
            dout_next     = rx_rd;
            rx_head_next  = (rx_head == RxPtrW'(RX_DEPTH - 1)) ? '0 :
                            RxPtrW'(rx_head + 1'b1);
            rx_count_next = RxCntW'(rx_count - 1'b1);
            acc_next      = 1'b1;
          end
        end
        default: acc_next = 1'b0;
      endcase
    end
  end

  // The read ports always present the entry at the next head pointer, so a
  // write into the empty FIFO is forwarded to the read register.
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_tail] <= data_in_r;
    end
    if (tx_we && tx_tail == tx_head_next) begin
      tx_rd <= data_in_r;
    end else begin
      tx_rd <= tx_mem[tx_head_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_tail] <= rx_shift;
    end
    if (rx_we && rx_tail == rx_head_next) begin
      rx_rd <= rx_shift;
    end else begin
      rx_rd <= rx_mem[rx_head_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_head       <= '0;
      tx_tail       <= '0;
      tx_count      <= '0;
      rx_head       <= '0;
      rx_tail       <= '0;
      rx_count      <= '0;
      tx_mode       <= MODE_IDLE;
      tx_bit_index  <= '0;
      tx_half       <= 1'b0;
      line_out      <= 1'b1;
      rx_mode       <= MODE_IDLE;
      rx_shift      <= '0;
      rx_bit_index  <= '0;
      rx_half       <= 1'b0;
      rx_delay      <= '0;
      overflow_flag <= 1'b0;
    end else begin
      tx_head       <= tx_head_next;
      tx_tail       <= tx_tail_next;
      tx_count      <= tx_count_next;
      rx_head       <= rx_head_next;
      rx_tail       <= rx_tail_next;
      rx_count      <= rx_count_next;
      tx_mode       <= tx_mode_next;
      tx_bit_index  <= tx_bit_index_next;
      tx_half       <= tx_half_next;
      line_out      <= line_out_next;
      rx_mode       <= rx_mode_next;
      rx_shift      <= rx_shift_next;
      rx_bit_index  <= rx_bit_index_next;
      rx_half       <= rx_half_next;
      rx_delay      <= rx_delay_next;
      overflow_flag <= overflow_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx_level <= line_out_next;
      data_out <= dout_next;
      accepted <= acc_next;
      rx_fill  <= FILL_W'(rx_count_next);
      tx_fill  <= FILL_W'(tx_count_next);
      overflow <= overflow_flag_next;
    end
  end

  `TDU_ASSERT_SAME(a_tx_ptr_match, tx_tail == tx_head, tx_count == '0 || tx_count == TxCntW'(TX_DEPTH), "TX pointers disagree with TX fill")
  `TDU_ASSERT_SAME(a_rx_ptr_match, rx_tail == rx_head, rx_count == '0 || rx_count == RxCntW'(RX_DEPTH), "RX pointers disagree with RX fill")
  `TDU_ASSERT_SAME(a_tx_busy_has_byte, tx_mode != MODE_IDLE, tx_count != '0, "Transmitter busy with an empty TX FIFO")
  `TDU_ASSERT_SAME(a_rx_start_clean, rx_mode == MODE_START, rx_bit_index == '0 && rx_shift == '0, "Receiver started with stale bits")
  `TDU_ASSERT_NEXT(a_advance_result, advance, out_valid, "Processed request produced no result")

endmodule

`default_nettype wire
